### rtl/spn_pkg.sv
// Shared types, constants and round functions of the 16-bit SPN block cipher.
package spn_pkg;

  localparam int BlockWidth = 16;
  localparam int KeyCount = 5;
  localparam int CfgIndexWidth = 3;

  typedef logic [BlockWidth-1:0] block_t;
  typedef logic [CfgIndexWidth-1:0] cfg_index_t;

  localparam cfg_index_t CfgRoundKey0 = 3'd0;
  localparam cfg_index_t CfgRoundKey1 = 3'd1;
  localparam cfg_index_t CfgRoundKey2 = 3'd2;
  localparam cfg_index_t CfgRoundKey3 = 3'd3;
  localparam cfg_index_t CfgFinalKey = 3'd4;

  localparam block_t ResetRoundKey0 = 16'h4354;
  localparam block_t ResetRoundKey1 = 16'h23F3;
  localparam block_t ResetRoundKey2 = 16'h5FEA;
  localparam block_t ResetRoundKey3 = 16'h9812;
  localparam block_t ResetFinalKey = 16'h0808;

  localparam logic [3:0] SBOX [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };

  function automatic block_t substitute(input block_t v);
    block_t res;
    res = '0;
    for (int n = 0; n < 4; n++) begin
      res[4*n +: 4] = SBOX[v[4*n +: 4]];
    end
    return res;
  endfunction

  // Bit 4*r + c moves to bit 4*c + r.
  function automatic block_t transpose(input block_t v);
    block_t res;
    res = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        res[4*c + r] = v[4*r + c];
      end
    end
    return res;
  endfunction

endpackage

### rtl/spn_round.sv
// One pipeline stage of the cipher: key mixing and nibble substitution, registered.
module spn_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  spn_pkg::block_t in_data,
  input  spn_pkg::block_t key,
  output logic            out_valid,
  input  logic            out_ready,
  output spn_pkg::block_t out_data
);
  import spn_pkg::*;

  logic   valid;
  block_t data;

  assign in_ready = !valid || out_ready;
  assign out_valid = valid;
  assign out_data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= substitute(in_data ^ key);
    end
  end

endmodule

### rtl/spn_block_encrypt_16bit.sv
// Top level of the pipelined four-round 16-bit SPN block cipher.
// The block encrypts one 16-bit plaintext per request on the s_axis channel
// and delivers the ciphertext on the m_axis channel, in order, one result
// for each request. Five pipeline stages lie between the channels: one for
// each of the four rounds and one for the final key mixing, and a request
// accepted on s_axis passes through all five before it is offered on m_axis.
// With the receiver ready the block takes one request every cycle.
// The five round keys are written through the cfg port (cfg_we, cfg_index,
// cfg_data) and should only change while no request is in flight; writes to
// an index beyond the final key are ignored.
// A synchronous reset empties the pipeline and loads the default keys.
// When the receiver stalls, the result is held on m_axis and the stages
// behind it keep filling; s_axis_tready falls only once every stage holds
// a request, and nothing is lost or repeated.
module spn_block_encrypt_16bit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  spn_pkg::block_t          s_axis_tdata,  // [15:0] plaintext
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output spn_pkg::block_t          m_axis_tdata,  // [15:0] ciphertext
  input  logic                     cfg_we,
  input  spn_pkg::cfg_index_t      cfg_index,
  input  spn_pkg::block_t          cfg_data
);
  import spn_pkg::*;

  block_t round_key [4];
  block_t final_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_key[0] <= ResetRoundKey0;
      round_key[1] <= ResetRoundKey1;
      round_key[2] <= ResetRoundKey2;
      round_key[3] <= ResetRoundKey3;
      final_key    <= ResetFinalKey;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgRoundKey0: round_key[0] <= cfg_data;
        CfgRoundKey1: round_key[1] <= cfg_data;
        CfgRoundKey2: round_key[2] <= cfg_data;
        CfgRoundKey3: round_key[3] <= cfg_data;
        CfgFinalKey:  final_key    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic   stage_valid [5];
  logic   stage_ready [5];
  block_t stage_in    [4];
  block_t stage_out   [4];

  assign stage_valid[0] = s_axis_tvalid;
  assign s_axis_tready = stage_ready[0];
  assign stage_in[0] = s_axis_tdata;

  for (genvar g = 0; g < 4; g++) begin : g_round
    spn_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[g]),
      .in_ready  (stage_ready[g]),
      .in_data   (stage_in[g]),
      .key       (round_key[g]),
      .out_valid (stage_valid[g+1]),
      .out_ready (stage_ready[g+1]),
      .out_data  (stage_out[g])
    );
    if (g < 3) begin : g_perm
      assign stage_in[g+1] = transpose(stage_out[g]);
    end
  end

  logic   out_valid;
  block_t out_data;

  assign stage_ready[4] = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_ready[4]) begin
      out_valid <= stage_valid[4];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[4] && stage_valid[4]) begin
      out_data <= stage_out[3] ^ final_key;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

endmodule

### tb/tb.sv
// Self-checking testbench for the pipelined 16-bit SPN block cipher, with its own predictor.
`timescale 1ns / 1ps

module tb;
  import spn_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ReportLimit = 10;
  localparam int RandomBlocksPerPhase = 380;

  localparam logic [3:0] SBOX_LUT [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };

  localparam block_t CORNER_PLAINTEXT [8] = '{
    16'h0000, 16'hFFFF, 16'h0123, 16'h4567, 16'h89AB, 16'hCDEF, 16'h5555, 16'hAAAA
  };

  typedef block_t key_set_t [KeyCount];

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  block_t     s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  block_t     m_axis_tdata;
  logic       cfg_we;
  cfg_index_t cfg_index;
  block_t     cfg_data;

  key_set_t    cipher_key;
  block_t      ciphertext_q [$];
  block_t      wanted_ciphertext;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_off_request;

  spn_block_encrypt_16bit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[spn_block_encrypt_16bit] ERROR");
      $finish;
    end
  end

  function automatic block_t encrypt_block(input block_t plaintext);
    block_t st;
    block_t mixed;
    int     r;
    int     b;
    st = plaintext;
    for (r = 0; r < 4; r++) begin
      st = st ^ cipher_key[r];
      for (b = 0; b < 4; b++) begin
        mixed[4*b +: 4] = SBOX_LUT[st[4*b +: 4]];
      end
      if (r < 3) begin
        for (b = 0; b < 16; b++) begin
          st[(b % 4) * 4 + b / 4] = mixed[b];
        end
      end else begin
        st = mixed;
      end
    end
    return st ^ cipher_key[KeyCount-1];
  endfunction

  // The receiver either serves a requested hold-off or stalls at random.
  initial begin
    int unsigned hold_cycles;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        hold_cycles = hold_off_request;
        hold_off_request = 0;
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (ciphertext_q.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $display("unexpected ciphertext %h with no request outstanding", m_axis_tdata);
        end
      end else begin
        wanted_ciphertext = ciphertext_q.pop_front();
        if (m_axis_tdata !== wanted_ciphertext) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("ciphertext mismatch: expected %h, got %h",
                     wanted_ciphertext, m_axis_tdata);
          end
        end
      end
    end
  end

  task automatic send_plaintext(input block_t plaintext);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= plaintext;
    do @(posedge clk); while (!s_axis_tready);
    ciphertext_q.push_back(encrypt_block(plaintext));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (ciphertext_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes all five keys, then one write to an unused index that must be ignored.
  task automatic load_keys(input key_set_t keys);
    int i;
    for (i = 0; i < KeyCount; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= keys[i];
      @(posedge clk);
      cipher_key[i] = keys[i];
    end
    cfg_index <= cfg_index_t'($urandom_range((1 << CfgIndexWidth) - 1, KeyCount));
    cfg_data  <= block_t'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_default_keys();
    foreach (CORNER_PLAINTEXT[i]) send_plaintext(CORNER_PLAINTEXT[i]);
    wait_drained();
  endtask

  task automatic test_key_extremes();
    key_set_t keys;
    int       k;
    int       n;
    for (k = 0; k < 3; k++) begin
      foreach (keys[i]) begin
        case (k)
          0: keys[i] = 16'h0000;
          1: keys[i] = 16'hFFFF;
          default: keys[i] = (i % 2) ? 16'hAAAA : 16'h5555;
        endcase
      end
      load_keys(keys);
      for (n = 0; n < 4; n++) send_plaintext(CORNER_PLAINTEXT[(2 * n + k) % 8]);
      wait_drained();
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall);
    key_set_t keys;
    int       n;
    foreach (keys[i]) keys[i] = block_t'($urandom);
    load_keys(keys);
    send_idle_pct = idle;
    stall_pct = stall;
    for (n = 0; n < RandomBlocksPerPhase; n++) send_plaintext(block_t'($urandom));
    wait_drained();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // A long receiver hold-off while requests keep coming fills every stage.
  task automatic test_backpressure();
    key_set_t keys;
    int       n;
    foreach (keys[i]) keys[i] = block_t'($urandom);
    load_keys(keys);
    hold_off_request = 300;
    for (n = 0; n < 60; n++) send_plaintext(block_t'($urandom));
    wait_drained();
  endtask

  initial begin
    cipher_key[CfgRoundKey0] = ResetRoundKey0;
    cipher_key[CfgRoundKey1] = ResetRoundKey1;
    cipher_key[CfgRoundKey2] = ResetRoundKey2;
    cipher_key[CfgRoundKey3] = ResetRoundKey3;
    cipher_key[CfgFinalKey]  = ResetFinalKey;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_off_request = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_keys();
    test_key_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(72, 0);
    test_random_traffic(0, 72);
    test_random_traffic(10, 10);
    test_backpressure();

    repeat (10) @(posedge clk);
    if (fail_count == 0 && ciphertext_q.size() == 0) begin
      $display("[spn_block_encrypt_16bit] OK");
    end else begin
      $display("[spn_block_encrypt_16bit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/spn_pkg.sv
rtl/spn_round.sv
rtl/spn_block_encrypt_16bit.sv
tb/tb.sv
